@@ rtl/assert_macros.svh @@
// Assertion macros, used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/trwa_pkg.sv @@
// Package: types, constants and the CORDIC angle table of the wrench accumulator.
package trwa_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgThrustCoeff = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMotorWeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMountWeight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCgX = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCgY = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCgZ = 3'd5;

  localparam logic [31:0] ThrustCoeffReset = 32'd20681000;
  localparam logic [19:0] MotorWeightReset = 20'd23788;
  localparam logic [19:0] MountWeightReset = 20'd64291;

  localparam int CordicSteps = 16;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  localparam logic signed [31:0] ForceMax = 32'sh7fffffff;
  localparam logic signed [31:0] ForceMin = 32'sh80000000;
  localparam logic signed [47:0] MomentMax = 48'sh7fffffffffff;
  localparam logic signed [47:0] MomentMin = 48'sh800000000000;

  typedef struct packed {
    logic [15:0]        tilt_angle;
    logic [15:0]        speed_rpm;
    logic signed [15:0] motor_px;
    logic signed [15:0] motor_py;
    logic signed [15:0] motor_pz;
    logic signed [15:0] mount_px;
    logic signed [15:0] mount_py;
    logic signed [15:0] mount_pz;
    logic signed [15:0] unit_px;
    logic signed [15:0] unit_py;
    logic signed [15:0] unit_pz;
    logic               last_unit;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [47:0] moment_x;
    logic signed [47:0] moment_y;
    logic signed [47:0] moment_z;
  } out_item_t;

  // Datapath operations sequenced by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RPM2, OP_THRUST, OP_CORDIC, OP_QUAD,
    OP_FX, OP_FZ, OP_FORCE, OP_MX, OP_MY, OP_MZ, OP_ACCUM, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] step;
  } dp_cmd_t;

  function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
    logic signed [33:0] r;
    unique case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667330;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679839;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tilt_rotor_wrench_accumulator_unit.sv @@
// Top level of the tilt-rotor wrench accumulator.
// Each item is worked through in full before the next is accepted; most of that work
// is a 16-step CORDIC on one shared rotation stage, and one shared multiplier serves
// the thrust projections. A last item also passes an emit step and waits there while
// the previous result has not yet been taken. A finished result sits in an output
// register while the next item is already being worked on.
`include "assert_macros.svh"
module tilt_rotor_wrench_accumulator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  trwa_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output trwa_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [trwa_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [trwa_pkg::CfgDataW-1:0]  cfg_data
);

  trwa_pkg::dp_cmd_t cmd;
  logic              item_last;

  trwa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .item_last, .cmd
  );

  trwa_datapath u_dp (
    .clk, .rst, .cmd, .in_item, .cfg_we, .cfg_idx, .cfg_data, .item_last,
    .result(out_item)
  );

  // A new result is never loaded over one that is still waiting.
  `CHK_IMPL(a_no_overwrite, cmd.op == trwa_pkg::OP_EMIT, !out_valid || out_ready,
            "result overwritten")
  // Emitting always raises the output valid.
  `CHK_NEXT(a_emit_valid, cmd.op == trwa_pkg::OP_EMIT, out_valid, "emit lost")
  // Acceptance always starts the item in the datapath.
  `CHK_IMPL(a_load, in_valid && in_ready, cmd.op == trwa_pkg::OP_LOAD,
            "item not loaded")

endmodule

@@ rtl/trwa_datapath.sv @@
// Datapath: thrust, CORDIC, forces, moments and saturating accumulators.
module trwa_datapath (
  input  logic               clk,
  input  logic               rst,
  input  trwa_pkg::dp_cmd_t  cmd,
  input  trwa_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  logic [trwa_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [trwa_pkg::CfgDataW-1:0] cfg_data,
  output logic               item_last,
  output trwa_pkg::out_item_t result
);

  // Configuration registers.
  logic [31:0]        thrust_coeff;
  logic [19:0]        motor_weight;
  logic [19:0]        mount_weight;
  logic signed [15:0] cg_x, cg_y, cg_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_coeff <= trwa_pkg::ThrustCoeffReset;
      motor_weight <= trwa_pkg::MotorWeightReset;
      mount_weight <= trwa_pkg::MountWeightReset;
      cg_x <= '0;
      cg_y <= '0;
      cg_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        trwa_pkg::CfgThrustCoeff: thrust_coeff <= cfg_data;
        trwa_pkg::CfgMotorWeight: motor_weight <= cfg_data[19:0];
        trwa_pkg::CfgMountWeight: mount_weight <= cfg_data[19:0];
        trwa_pkg::CfgCgX:         cg_x <= cfg_data[15:0];
        trwa_pkg::CfgCgY:         cg_y <= cfg_data[15:0];
        trwa_pkg::CfgCgZ:         cg_z <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Working registers of one item.
  trwa_pkg::in_item_t itm;
  logic [31:0]        rpm2;
  logic [31:0]        thrust;
  logic signed [33:0] cx, cy, cz;
  logic signed [33:0] sn, cs;
  logic signed [33:0] fax, faz;       // thrust+motor force, x and z
  logic signed [33:0] ftx, ftz;       // total unit force, x and z
  logic signed [16:0] d1x, d1y, d1z, d2x, d2y, d3x, d3y, d3z;
  logic signed [55:0] mx, my, mz;
  logic signed [31:0] fsum_x, fsum_y, fsum_z;
  logic signed [47:0] msum_x, msum_y, msum_z;

  assign item_last = itm.last_unit;

  // Combinational helpers.
  logic signed [33:0] ddx, ddy;
  logic signed [65:0] tprod;
  logic signed [33:0] cxc, cyc;
  logic signed [33:0] ws;

  assign ddx = cy >>> cmd.step;
  assign ddy = cx >>> cmd.step;
  assign cxc = (cx > trwa_pkg::OneQ30) ? trwa_pkg::OneQ30 :
               (cx < -trwa_pkg::OneQ30) ? -trwa_pkg::OneQ30 : cx;
  assign cyc = (cy > trwa_pkg::OneQ30) ? trwa_pkg::OneQ30 :
               (cy < -trwa_pkg::OneQ30) ? -trwa_pkg::OneQ30 : cy;
  // One shared 34x34 signed multiplier for the thrust projections.
  assign tprod = $signed({2'b00, thrust}) *
                 ((cmd.op == trwa_pkg::OP_FX) ? sn : cs);
  assign ws = $signed({14'd0, mount_weight});

  function automatic logic signed [55:0] sat_add_m(input logic signed [47:0] a,
                                                   input logic signed [55:0] b);
    logic signed [56:0] s;
    s = 57'(a) + 57'(b);
    if (s > 57'(trwa_pkg::MomentMax)) return 56'(trwa_pkg::MomentMax);
    if (s < 57'(trwa_pkg::MomentMin)) return 56'(trwa_pkg::MomentMin);
    return s[55:0];
  endfunction

  function automatic logic signed [31:0] sat_add_f(input logic signed [31:0] a,
                                                   input logic signed [33:0] b);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b);
    if (s > 35'(trwa_pkg::ForceMax)) return trwa_pkg::ForceMax;
    if (s < 35'(trwa_pkg::ForceMin)) return trwa_pkg::ForceMin;
    return s[31:0];
  endfunction

  // Moment terms: d1 x fa + d2 x fs + d3 x ft, with fa_y = fs_x = fs_y = ft_y = 0.
  logic signed [55:0] mterm;
  always_comb begin
    unique case (cmd.op)
      trwa_pkg::OP_MX: mterm = 56'(d1y) * 56'(faz) - 56'(d2y) * 56'(ws)
                             + 56'(d3y) * 56'(ftz);
      trwa_pkg::OP_MY: mterm = 56'(d1z) * 56'(fax) - 56'(d1x) * 56'(faz)
                             + 56'(d2x) * 56'(ws)
                             + 56'(d3z) * 56'(ftx) - 56'(d3x) * 56'(ftz);
      trwa_pkg::OP_MZ: mterm = -(56'(d1y) * 56'(fax)) - 56'(d3y) * 56'(ftx);
      default: mterm = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsum_x <= '0; fsum_y <= '0; fsum_z <= '0;
      msum_x <= '0; msum_y <= '0; msum_z <= '0;
    end else begin
      unique case (cmd.op)
        trwa_pkg::OP_LOAD: begin
          itm <= in_item;
          cx <= trwa_pkg::CordicStart;
          cy <= '0;
          cz <= $signed({4'd0, in_item.tilt_angle[13:0], 16'd0});
        end
        trwa_pkg::OP_RPM2: begin
          rpm2 <= itm.speed_rpm * itm.speed_rpm;
          d1x <= 17'(itm.unit_px) - 17'(itm.motor_px);
          d1y <= 17'(itm.unit_py) - 17'(itm.motor_py);
          d1z <= 17'(itm.unit_pz) - 17'(itm.motor_pz);
          d2x <= 17'(itm.unit_px) - 17'(itm.mount_px);
          d2y <= 17'(itm.unit_py) - 17'(itm.mount_py);
          d3x <= 17'(cg_x) - 17'(itm.unit_px);
          d3y <= 17'(cg_y) - 17'(itm.unit_py);
          d3z <= 17'(cg_z) - 17'(itm.unit_pz);
        end
        trwa_pkg::OP_THRUST: begin
          thrust <= 32'(({32'd0, thrust_coeff} * {32'd0, rpm2}) >> 32);
        end
        trwa_pkg::OP_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - ddx; cy <= cy + ddy; cz <= cz - trwa_pkg::atan_turn(cmd.step);
          end else begin
            cx <= cx + ddx; cy <= cy - ddy; cz <= cz + trwa_pkg::atan_turn(cmd.step);
          end
        end
        trwa_pkg::OP_QUAD: begin
          unique case (itm.tilt_angle[15:14])
            2'd0: begin cs <= cxc;  sn <= cyc;  end
            2'd1: begin cs <= -cyc; sn <= cxc;  end
            2'd2: begin cs <= -cxc; sn <= -cyc; end
            default: begin cs <= cyc; sn <= -cxc; end
          endcase
        end
        trwa_pkg::OP_FX: fax <= 34'(-(tprod >>> 30)) - 34'((tprod[29:0] != 0) ? 1 : 0);
        trwa_pkg::OP_FZ: faz <= 34'(tprod >>> 30) - $signed({14'd0, motor_weight});
        trwa_pkg::OP_FORCE: begin
          ftx <= fax;
          ftz <= faz - ws;
        end
        trwa_pkg::OP_MX: mx <= mterm;
        trwa_pkg::OP_MY: my <= mterm;
        trwa_pkg::OP_MZ: mz <= mterm;
        trwa_pkg::OP_ACCUM: begin
          fsum_x <= sat_add_f(fsum_x, ftx);
          fsum_z <= sat_add_f(fsum_z, ftz);
          msum_x <= 48'(sat_add_m(msum_x, mx));
          msum_y <= 48'(sat_add_m(msum_y, my));
          msum_z <= 48'(sat_add_m(msum_z, mz));
        end
        trwa_pkg::OP_EMIT: begin
          result.force_x <= fsum_x; result.force_y <= fsum_y;
          result.force_z <= fsum_z;
          result.moment_x <= msum_x; result.moment_y <= msum_y;
          result.moment_z <= msum_z;
          fsum_x <= '0; fsum_y <= '0; fsum_z <= '0;
          msum_x <= '0; msum_y <= '0; msum_z <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/trwa_ctrl.sv @@
// Controller: sequences one item through the datapath and runs the handshakes.
module trwa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              item_last,
  output trwa_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RPM2   = 4'd1;
  localparam logic [3:0] S_THRUST = 4'd2;
  localparam logic [3:0] S_CORDIC = 4'd3;
  localparam logic [3:0] S_QUAD   = 4'd4;
  localparam logic [3:0] S_FX     = 4'd5;
  localparam logic [3:0] S_FZ     = 4'd6;
  localparam logic [3:0] S_FORCE  = 4'd7;
  localparam logic [3:0] S_MX     = 4'd8;
  localparam logic [3:0] S_MY     = 4'd9;
  localparam logic [3:0] S_MZ     = 4'd10;
  localparam logic [3:0] S_ACCUM  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] step, step_next;
  logic       out_valid_next;

  // Input is taken only when idle; the result register frees by itself.
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next = step;
    out_valid_next = out_valid && !out_ready;
    cmd.op = trwa_pkg::OP_NONE;
    cmd.step = step;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = trwa_pkg::OP_LOAD;
        state_next = S_RPM2;
      end
      S_RPM2:   begin cmd.op = trwa_pkg::OP_RPM2; state_next = S_THRUST; end
      S_THRUST: begin
        cmd.op = trwa_pkg::OP_THRUST; state_next = S_CORDIC; step_next = '0;
      end
      S_CORDIC: begin
        cmd.op = trwa_pkg::OP_CORDIC;
        step_next = step + 4'd1;
        if (step == 4'(trwa_pkg::CordicSteps - 1)) state_next = S_QUAD;
      end
      S_QUAD:  begin cmd.op = trwa_pkg::OP_QUAD;  state_next = S_FX; end
      S_FX:    begin cmd.op = trwa_pkg::OP_FX;    state_next = S_FZ; end
      S_FZ:    begin cmd.op = trwa_pkg::OP_FZ;    state_next = S_FORCE; end
      S_FORCE: begin cmd.op = trwa_pkg::OP_FORCE; state_next = S_MX; end
      S_MX:    begin cmd.op = trwa_pkg::OP_MX;    state_next = S_MY; end
      S_MY:    begin cmd.op = trwa_pkg::OP_MY;    state_next = S_MZ; end
      S_MZ:    begin cmd.op = trwa_pkg::OP_MZ;    state_next = S_ACCUM; end
      S_ACCUM: begin
        cmd.op = trwa_pkg::OP_ACCUM;
        state_next = item_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: if (!out_valid || out_ready) begin
        cmd.op = trwa_pkg::OP_EMIT;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the tilt-rotor wrench accumulator unit.
module testbench;
  import trwa_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;
  localparam int InBits = $bits(in_item_t);
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;

  typedef longint vec3_t [3];

  // Wrench model: holds its own registers and sums, and the expected totals.
  class wrench_scoreboard;
    logic [31:0] coeff;
    logic [19:0] motor_w;
    logic [19:0] mount_w;
    longint cg [3];
    longint force_acc [3];
    longint moment_acc [3];
    out_item_t totals_q [$];
    int errors;
    longint atan_tab [16];

    function new();
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667330, 21354465,
                   10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861};
      coeff = ThrustCoeffReset;
      motor_w = MotorWeightReset;
      mount_w = MountWeightReset;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        cg[i] = 0;
        force_acc[i] = 0;
        moment_acc[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgThrustCoeff: coeff = data;
        CfgMotorWeight: motor_w = data[19:0];
        CfgMountWeight: mount_w = data[19:0];
        CfgCgX: cg[0] = longint'($signed(data[15:0]));
        CfgCgY: cg[1] = longint'($signed(data[15:0]));
        CfgCgZ: cg[2] = longint'($signed(data[15:0]));
        default: ;
      endcase
    endfunction

    // Rotation CORDIC on the residue, then the quadrant swap.
    function void sin_cos(logic [15:0] angle, output longint s, output longint c);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'({angle[13:0], 16'b0});
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      if (x < -64'sd1073741824) x = -64'sd1073741824;
      if (y > 64'sd1073741824) y = 64'sd1073741824;
      if (y < -64'sd1073741824) y = -64'sd1073741824;
      case (angle[15:14])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void cross_add(vec3_t d, vec3_t f, inout vec3_t m);
      m[0] += d[1] * f[2] - d[2] * f[1];
      m[1] += d[2] * f[0] - d[0] * f[2];
      m[2] += d[0] * f[1] - d[1] * f[0];
    endfunction

    // Add one unit's wrench to the sums; a last unit yields the expected totals.
    function void note_input(in_item_t it);
      longint unsigned rpm, thrust;
      longint s, c, tmp;
      vec3_t fa, fs, ft, d1, d2, d3, m;
      out_item_t res;
      rpm = it.speed_rpm;
      thrust = (longint'(coeff) * (rpm * rpm)) >> 32;
      sin_cos(it.tilt_angle, s, c);
      tmp = -(longint'(thrust) * s);
      fa[0] = tmp >>> 30;
      fa[1] = 0;
      tmp = longint'(thrust) * c;
      fa[2] = (tmp >>> 30) - longint'(motor_w);
      fs[0] = 0; fs[1] = 0; fs[2] = -longint'(mount_w);
      d1[0] = it.unit_px - it.motor_px;
      d1[1] = it.unit_py - it.motor_py;
      d1[2] = it.unit_pz - it.motor_pz;
      d2[0] = it.unit_px - it.mount_px;
      d2[1] = it.unit_py - it.mount_py;
      d2[2] = it.unit_pz - it.mount_pz;
      d3[0] = cg[0] - it.unit_px;
      d3[1] = cg[1] - it.unit_py;
      d3[2] = cg[2] - it.unit_pz;
      for (int i = 0; i < 3; i++) begin
        ft[i] = fa[i] + fs[i];
        m[i] = 0;
      end
      cross_add(d1, fa, m);
      cross_add(d2, fs, m);
      cross_add(d3, ft, m);
      // Saturating accumulation after every unit.
      for (int i = 0; i < 3; i++) begin
        force_acc[i] += ft[i];
        if (force_acc[i] > 64'sd2147483647) force_acc[i] = 64'sd2147483647;
        if (force_acc[i] < -64'sd2147483648) force_acc[i] = -64'sd2147483648;
        moment_acc[i] += m[i];
        if (moment_acc[i] > 64'sd140737488355327) moment_acc[i] = 64'sd140737488355327;
        if (moment_acc[i] < -64'sd140737488355328) moment_acc[i] = -64'sd140737488355328;
      end
      if (it.last_unit) begin
        res.force_x = force_acc[0][31:0];
        res.force_y = force_acc[1][31:0];
        res.force_z = force_acc[2][31:0];
        res.moment_x = moment_acc[0][47:0];
        res.moment_y = moment_acc[1][47:0];
        res.moment_z = moment_acc[2][47:0];
        totals_q.push_back(res);
        for (int i = 0; i < 3; i++) begin
          force_acc[i] = 0;
          moment_acc[i] = 0;
        end
      end
    endfunction

    task compare_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (totals_q.size() == 0) begin
        report("result with no totals pending");
        return;
      end
      want = totals_q.pop_front();
      compare_field("force_x", got.force_x, want.force_x);
      compare_field("force_y", got.force_y, want.force_y);
      compare_field("force_z", got.force_z, want.force_z);
      compare_field("moment_x", got.moment_x, want.moment_x);
      compare_field("moment_y", got.moment_y, want.moment_y);
      compare_field("moment_z", got.moment_z, want.moment_z);
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  wrench_scoreboard sb = new();
  bit quiet;
  int cycles;

  tilt_rotor_wrench_accumulator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // Receiver stalls in random bursts, except in the quiet phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Offer one item, optionally after an idle burst, and hold it until taken.
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Drop valid and wait until every total has arrived and the block has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.totals_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] coeff, logic [19:0] mw, logic [19:0] nw,
                            logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    wait_idle();
    write_reg(CfgThrustCoeff, coeff);
    write_reg(CfgMotorWeight, {12'hfff, mw});
    write_reg(CfgMountWeight, {12'hfff, nw});
    write_reg(CfgCgX, {16'hffff, cx});
    write_reg(CfgCgY, {16'h0000, cy});
    write_reg(CfgCgZ, {16'($urandom_range(0, 65535)), cz});
    @(negedge clk);
  endtask

  function automatic in_item_t rand_item(bit last);
    in_item_t it;
    it = InBits'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom()});
    if ($urandom_range(0, 3) == 0)
      it.tilt_angle = {2'($urandom_range(0, 3)), 14'h0000};
    it.last_unit = last;
    return it;
  endfunction

  function automatic in_item_t fixed_item(logic [15:0] ang, logic [15:0] rpm,
                                          logic [15:0] p, bit last);
    in_item_t it;
    it.tilt_angle = ang;
    it.speed_rpm = rpm;
    it.motor_px = p; it.motor_py = ~p; it.motor_pz = p;
    it.mount_px = ~p; it.mount_py = p; it.mount_pz = ~p;
    it.unit_px = p; it.unit_py = p; it.unit_pz = ~p;
    it.last_unit = last;
    return it;
  endfunction

  initial begin
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgThrustCoeff;
    cfg_data = '0;
    quiet = 1'b0;
    cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: quadrant boundaries, extreme speeds and positions, reset settings.
    send_item(fixed_item(16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(fixed_item(16'h4000, 16'hffff, 16'h7fff, 1'b0));
    send_item(fixed_item(16'h8000, 16'hffff, 16'h8000, 1'b0));
    send_item(fixed_item(16'hc000, 16'h1234, 16'h7fff, 1'b1));
    send_item(fixed_item(16'hffff, 16'hffff, 16'h8000, 1'b1));
    send_item(fixed_item(16'h2000, 16'h8000, 16'h0001, 1'b0));
    send_item(fixed_item(16'h3fff, 16'h0001, 16'hffff, 1'b1));

    // Largest settings: one unit alone saturates the force and moment sums.
    set_config(32'hffffffff, 20'hfffff, 20'hfffff, 16'h7fff, 16'h8000, 16'h7fff);
    write_reg(CfgSpare6, $urandom());
    write_reg(CfgSpare7, $urandom());
    for (int i = 0; i < 6; i++)
      send_item(fixed_item(16'h4000 * i[1:0], 16'hffff,
                           i[0] ? 16'h8000 : 16'h7fff, i == 2 || i == 5));

    // Smallest settings.
    set_config(32'h0, 20'h0, 20'h0, 16'h8000, 16'h7fff, 16'h8000);
    for (int i = 0; i < 4; i++)
      send_item(fixed_item(16'hc000, 16'hffff, 16'h8000, i == 3));

    // Random phases: mostly well-formed groups of units, some noise.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        wait_idle();
        quiet = 1'b1;
      end
      set_config($urandom(), 20'($urandom_range(0, 20'hfffff)),
                 20'($urandom_range(0, 20'hfffff)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      n = 0;
      while (n < 96) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(rand_item(1'($urandom_range(0, 1))));
          n++;
        end else begin
          int units;
          units = $urandom_range(1, 6);
          for (int u = 0; u < units; u++) send_item(rand_item(u == units - 1));
          n += units;
        end
      end
      // Close any open group so every phase ends with its totals out.
      send_item(rand_item(1'b1));
    end

    in_valid <= 1'b0;
    while (sb.totals_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.totals_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
